/* rtl/dbva_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbva_pkg
// Shared constants and types for the distance band volume attenuator.
// ----------------------------------------------------------------------------
package dbva_pkg;

    localparam int GRID_SIZE_DEF = 16;
    localparam int BANDS_DEF     = 6;

    localparam int VOL_W      = 7;
    localparam int RNG_W      = 8;
    localparam int CFG_BANDS  = 6;
    localparam int COORD_W    = 32;
    localparam int FRAC_W     = 12;
    localparam int SRC_W      = 16;
    localparam int VOLS_W     = CFG_BANDS * VOL_W;
    localparam int RNGS_W     = CFG_BANDS * RNG_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    // divider: number of stages that produce the quotient bits
    localparam int DIV_STAGES = 4;

    // pipeline layout
    localparam int AXIS_STAGES = 5 + DIV_STAGES;
    localparam int MIX_STAGES  = 4;
    localparam int NUM_STAGES  = AXIS_STAGES + MIX_STAGES;

    // scale by 1/(127*127): multiply by a rounded-up reciprocal and shift
    localparam int          FULL_SCALE_SQ = 127 * 127;
    localparam int          PROD_W        = 3 * VOL_W;
    localparam int          RECIP_SH      = 36;
    localparam int          RECIP_W       = 23;
    localparam logic [63:0] RECIP_M64     =
        ((64'd1 << RECIP_SH) + 64'(FULL_SCALE_SQ) - 64'd1) / 64'(FULL_SCALE_SQ);
    localparam logic [RECIP_W-1:0] RECIP_M = RECIP_M64[RECIP_W-1:0];
    localparam int          SCALED_W      = PROD_W + RECIP_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VOLUMES  = 3'd0,
        CFG_RANGES_X = 3'd1,
        CFG_RANGES_Y = 3'd2,
        CFG_RANGES_Z = 3'd3,
        CFG_SRC_X    = 3'd4,
        CFG_SRC_Y    = 3'd5,
        CFG_SRC_Z    = 3'd6
    } cfg_reg_t;

endpackage

/* rtl/dbva_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbva_div
// Pipelined restoring divider for unsigned numerator and divisor, with a
// sideband bus that travels alongside.
// ----------------------------------------------------------------------------
module dbva_div #(
    parameter int DEN_W  = 13,
    parameter int NUM_W  = 20,
    parameter int Q_W    = 7,
    parameter int SIDE_W = 9
) (
    input  logic                                aclk,
    input  logic [dbva_pkg::DIV_STAGES-1:0]     en,
    input  logic [NUM_W-1:0]                    num,
    input  logic [DEN_W-1:0]                    den,
    input  logic [SIDE_W-1:0]                   side_in,
    output logic [Q_W-1:0]                      quot,
    output logic [SIDE_W-1:0]                   side_out
);

    localparam int ST  = dbva_pkg::DIV_STAGES;
    localparam int BPS = (Q_W + ST - 1) / ST;

    logic [NUM_W-1:0]  rem_reg  [ST];
    logic [NUM_W-1:0]  rem_next [ST];
    logic [Q_W-1:0]    q_reg    [ST];
    logic [Q_W-1:0]    q_next   [ST];
    logic [DEN_W-1:0]  den_reg  [ST];
    logic [SIDE_W-1:0] side_reg [ST];

    always_comb begin
        logic [NUM_W-1:0] r;
        logic [NUM_W-1:0] t;
        logic [Q_W-1:0]   q;
        int               bi;
        for (int j = 0; j < ST; j++) begin
            r = (j == 0) ? num : rem_reg[(j == 0) ? 0 : j - 1];
            q = (j == 0) ? '0 : q_reg[(j == 0) ? 0 : j - 1];
            for (int b = 0; b < BPS; b++) begin
                bi = Q_W - 1 - j * BPS - b;
                if (bi >= 0) begin
                    t = NUM_W'(((j == 0) ? den : den_reg[(j == 0) ? 0 : j - 1])) << bi;
                    if (r >= t) begin
                        r     = r - t;
                        q[bi] = 1'b1;
                    end
                end
            end
            rem_next[j] = r;
            q_next[j]   = q;
        end
    end

    always_ff @(posedge aclk) begin
        for (int j = 0; j < ST; j++) begin
            if (en[j]) begin
                rem_reg[j]  <= rem_next[j];
                q_reg[j]    <= q_next[j];
                den_reg[j]  <= (j == 0) ? den : den_reg[(j == 0) ? 0 : j - 1];
                side_reg[j] <= (j == 0) ? side_in : side_reg[(j == 0) ? 0 : j - 1];
            end
        end
    end

    assign quot     = q_reg[ST-1];
    assign side_out = side_reg[ST-1];

endmodule

/* rtl/dbva_axis.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbva_axis
// One axis: distance to the source centre, band search, interpolation
// product and divide, giving the axis volume and a fault flag.
// ----------------------------------------------------------------------------
module dbva_axis #(
    parameter int GRID_SIZE = dbva_pkg::GRID_SIZE_DEF,
    parameter int BANDS     = dbva_pkg::BANDS_DEF
) (
    input  logic                                  aclk,
    input  logic [dbva_pkg::AXIS_STAGES-1:0]      en,
    input  logic signed [dbva_pkg::COORD_W-1:0]   coord,
    input  logic [dbva_pkg::RNGS_W-1:0]           ranges,
    input  logic [dbva_pkg::VOLS_W-1:0]           volumes,
    input  logic signed [dbva_pkg::SRC_W-1:0]     src,
    output logic [dbva_pkg::VOL_W-1:0]            vol,
    output logic                                  fault
);

    localparam int VW      = dbva_pkg::VOL_W;
    localparam int G_W     = $clog2(GRID_SIZE + 1);
    localparam int CTR_W   = dbva_pkg::SRC_W + G_W + 1;
    localparam int WHOLE_W = dbva_pkg::COORD_W - dbva_pkg::FRAC_W;
    localparam int SUM_W   = ((CTR_W > WHOLE_W) ? CTR_W : WHOLE_W) + 1;
    localparam int RG_W    = dbva_pkg::RNG_W + G_W;
    localparam int NUM_W   = VW + RG_W;
    localparam int SIDE_W  = VW + 2;
    localparam int DS      = dbva_pkg::DIV_STAGES;

    // band tables from the configuration words
    logic [VW-1:0]   vol_a [BANDS];
    logic [RG_W-1:0] rg_a  [BANDS];

    for (genvar k = 0; k < BANDS; k++) begin : g_band
        if (k < dbva_pkg::CFG_BANDS) begin : g_cfg
            assign vol_a[k] = volumes[VW*k +: VW];
            assign rg_a[k]  = RG_W'(ranges[dbva_pkg::RNG_W*k +: dbva_pkg::RNG_W])
                            * RG_W'(GRID_SIZE);
        end else begin : g_zero
            assign vol_a[k] = '0;
            assign rg_a[k]  = '0;
        end
    end

    // stage 0: absolute distance from the floored coordinate to the centre
    logic signed [CTR_W-1:0]   ctr_base, ctr;
    logic signed [WHOLE_W-1:0] whole;
    logic signed [SUM_W-1:0]   diff;
    logic [SUM_W-1:0]          dist_next, dist_reg;

    assign ctr_base = CTR_W'(src) * CTR_W'(GRID_SIZE) + CTR_W'(GRID_SIZE / 2);
    // odd grid: centre sits on a half, truncation pulls negatives up
    assign ctr   = ((GRID_SIZE % 2) != 0 && ctr_base < 0) ? ctr_base + 1'b1 : ctr_base;
    assign whole = coord[dbva_pkg::COORD_W-1:dbva_pkg::FRAC_W];
    assign diff  = SUM_W'(whole) - SUM_W'(ctr);
    assign dist_next = diff[SUM_W-1] ? SUM_W'(-diff) : SUM_W'(diff);

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            dist_reg <= dist_next;
        end
    end

    // stage 1: first band whose start lies at or below the distance
    logic            s1_found_next, s1_is0_next;
    logic [VW-1:0]   s1_sv_next, s1_ev_next;
    logic [RG_W-1:0] s1_sp_next, s1_ep_next;
    logic            s1_found_reg, s1_is0_reg;
    logic [VW-1:0]   s1_sv_reg, s1_ev_reg;
    logic [RG_W-1:0] s1_sp_reg, s1_ep_reg;
    logic [SUM_W-1:0] s1_dist_reg;

    always_comb begin
        s1_found_next = 1'b0;
        s1_is0_next   = 1'b0;
        s1_sv_next    = vol_a[0];
        s1_ev_next    = '0;
        s1_sp_next    = '0;
        s1_ep_next    = '0;
        for (int k = BANDS - 1; k >= 0; k--) begin
            if (SUM_W'(rg_a[k]) <= dist_reg) begin
                s1_found_next = 1'b1;
                s1_is0_next   = (k == 0);
                s1_sv_next    = vol_a[k];
                s1_ev_next    = vol_a[(k > 0) ? k - 1 : 0];
                s1_sp_next    = rg_a[k];
                s1_ep_next    = rg_a[(k > 0) ? k - 1 : 0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            s1_found_reg <= s1_found_next;
            s1_is0_reg   <= s1_is0_next;
            s1_sv_reg    <= s1_sv_next;
            s1_ev_reg    <= s1_ev_next;
            s1_sp_reg    <= s1_sp_next;
            s1_ep_reg    <= s1_ep_next;
            s1_dist_reg  <= dist_reg;
        end
    end

    // stage 2: interpolation operands; band 0 or no match takes the base volume
    logic signed [VW:0] s2_dv_next, s2_dv_reg;
    logic [RG_W-1:0]    s2_off_next, s2_den_next, s2_off_reg, s2_den_reg;
    logic [SUM_W-1:0]   off_full;
    logic [VW-1:0]      s2_sv_reg;
    logic               s2_fault_reg;

    assign off_full = s1_dist_reg - SUM_W'(s1_sp_reg);

    always_comb begin
        if (!s1_found_reg || s1_is0_reg) begin
            s2_dv_next  = '0;
            s2_off_next = '0;
            s2_den_next = RG_W'(1);
        end else begin
            s2_dv_next  = signed'({1'b0, s1_ev_reg}) - signed'({1'b0, s1_sv_reg});
            s2_off_next = off_full[RG_W-1:0];
            s2_den_next = s1_ep_reg - s1_sp_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            s2_dv_reg    <= s2_dv_next;
            s2_off_reg   <= s2_off_next;
            s2_den_reg   <= s2_den_next;
            s2_sv_reg    <= s1_sv_reg;
            s2_fault_reg <= !s1_found_reg;
        end
    end

    // stage 3: numerator magnitude and sign
    logic [VW-1:0]    dv_mag;
    logic [NUM_W-1:0] s3_num_reg;
    logic [RG_W-1:0]  s3_den_reg;
    logic [SIDE_W-1:0] s3_side_reg;

    assign dv_mag = s2_dv_reg[VW] ? VW'(-s2_dv_reg) : VW'(s2_dv_reg);

    always_ff @(posedge aclk) begin
        if (en[3]) begin
            s3_num_reg  <= NUM_W'(dv_mag) * NUM_W'(s2_off_reg);
            s3_den_reg  <= s2_den_reg;
            s3_side_reg <= {s2_fault_reg, s2_dv_reg[VW], s2_sv_reg};
        end
    end

    // divide stages
    logic [VW-1:0]     quot;
    logic [SIDE_W-1:0] side_q;

    dbva_div #(
        .DEN_W  (RG_W),
        .NUM_W  (NUM_W),
        .Q_W    (VW),
        .SIDE_W (SIDE_W)
    ) u_div (
        .aclk     (aclk),
        .en       (en[4 +: DS]),
        .num      (s3_num_reg),
        .den      (s3_den_reg),
        .side_in  (s3_side_reg),
        .quot     (quot),
        .side_out (side_q)
    );

    // last stage: apply the truncated quotient to the base volume
    logic [VW-1:0] vol_next, vol_reg;
    logic          fault_reg;

    assign vol_next = side_q[VW] ? side_q[VW-1:0] - quot : side_q[VW-1:0] + quot;

    always_ff @(posedge aclk) begin
        if (en[4 + DS]) begin
            vol_reg   <= vol_next;
            fault_reg <= side_q[VW+1];
        end
    end

    assign vol   = vol_reg;
    assign fault = fault_reg;

endmodule

/* rtl/dbva_mix.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbva_mix
// Multiplies the three axis volumes and scales the product by 1/(127*127).
// ----------------------------------------------------------------------------
module dbva_mix (
    input  logic                                 aclk,
    input  logic [dbva_pkg::MIX_STAGES-1:0]      en,
    input  logic [dbva_pkg::VOL_W-1:0]           vol_x,
    input  logic [dbva_pkg::VOL_W-1:0]           vol_y,
    input  logic [dbva_pkg::VOL_W-1:0]           vol_z,
    input  logic                                 fault_in,
    output logic [dbva_pkg::VOL_W-1:0]           level,
    output logic                                 fault_out
);

    localparam int VW = dbva_pkg::VOL_W;
    localparam int PW = dbva_pkg::PROD_W;
    localparam int SW = dbva_pkg::SCALED_W;
    localparam int SH = dbva_pkg::RECIP_SH;

    logic [2*VW-1:0] p1_reg;
    logic [VW-1:0]   vz_reg;
    logic [PW-1:0]   p_reg;
    logic [SW-1:0]   sc_reg;
    logic [VW-1:0]   level_reg;
    logic [dbva_pkg::MIX_STAGES-1:0] fault_reg;

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            p1_reg       <= (2*VW)'(vol_x) * (2*VW)'(vol_y);
            vz_reg       <= vol_z;
            fault_reg[0] <= fault_in;
        end
        if (en[1]) begin
            p_reg        <= PW'(p1_reg) * PW'(vz_reg);
            fault_reg[1] <= fault_reg[0];
        end
        if (en[2]) begin
            sc_reg       <= SW'(p_reg) * SW'(dbva_pkg::RECIP_M);
            fault_reg[2] <= fault_reg[1];
        end
        if (en[3]) begin
            level_reg    <= sc_reg[SH +: VW];
            fault_reg[3] <= fault_reg[2];
        end
    end

    assign level     = level_reg;
    assign fault_out = fault_reg[dbva_pkg::MIX_STAGES-1];

endmodule

/* rtl/distance_band_volume_attenuator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// distance_band_volume_attenuator
// Listener position in, combined band volume and table fault out.
// ----------------------------------------------------------------------------
// Fully pipelined: a position is taken every cycle while the output side
// keeps up. Stages: distance, band search, operand setup, numerator
// multiply, four divider stages of up to two quotient bits each, axis volume,
// two volume multiplies, reciprocal scale, level select. Each stage
// holds its own valid bit, so a stalled output only holds stages that are
// full and bubbles behind it still close up. Configuration writes are taken
// every cycle and should be made while no position is in flight.
module distance_band_volume_attenuator #(
    parameter int GRID_SIZE = dbva_pkg::GRID_SIZE_DEF,
    parameter int BANDS     = dbva_pkg::BANDS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [dbva_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [dbva_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [dbva_pkg::COORD_W-1:0]   s_listener_x,
    input  logic signed [dbva_pkg::COORD_W-1:0]   s_listener_y,
    input  logic signed [dbva_pkg::COORD_W-1:0]   s_listener_z,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [dbva_pkg::VOL_W-1:0]            m_level,
    output logic                                  m_table_fault
);

    localparam int NS = dbva_pkg::NUM_STAGES;
    localparam int AS = dbva_pkg::AXIS_STAGES;

    // configuration registers
    logic [dbva_pkg::VOLS_W-1:0]       volumes_reg;
    logic [dbva_pkg::RNGS_W-1:0]       ranges_reg [3];
    logic signed [dbva_pkg::SRC_W-1:0] src_reg    [3];

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            volumes_reg <= '0;
            for (int a = 0; a < 3; a++) begin
                ranges_reg[a] <= '0;
                src_reg[a]    <= '0;
            end
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                dbva_pkg::CFG_VOLUMES:  volumes_reg   <= cfg_data[dbva_pkg::VOLS_W-1:0];
                dbva_pkg::CFG_RANGES_X: ranges_reg[0] <= cfg_data[dbva_pkg::RNGS_W-1:0];
                dbva_pkg::CFG_RANGES_Y: ranges_reg[1] <= cfg_data[dbva_pkg::RNGS_W-1:0];
                dbva_pkg::CFG_RANGES_Z: ranges_reg[2] <= cfg_data[dbva_pkg::RNGS_W-1:0];
                dbva_pkg::CFG_SRC_X:    src_reg[0]    <= cfg_data[dbva_pkg::SRC_W-1:0];
                dbva_pkg::CFG_SRC_Y:    src_reg[1]    <= cfg_data[dbva_pkg::SRC_W-1:0];
                dbva_pkg::CFG_SRC_Z:    src_reg[2]    <= cfg_data[dbva_pkg::SRC_W-1:0];
                default: ;  // drop writes to unused indexes
            endcase
        end
    end

    // stage flow control: a stage loads when it is empty or moves on itself
    logic [NS-1:0] valid_reg, valid_next;
    logic [NS:0]   load;

    always_comb begin
        load[NS] = m_ready;
        for (int i = NS - 1; i >= 0; i--) begin
            load[i] = !valid_reg[i] || load[i+1];
        end
        for (int i = 0; i < NS; i++) begin
            if (load[i]) begin
                valid_next[i] = (i == 0) ? s_valid : valid_reg[(i == 0) ? 0 : i - 1];
            end else begin
                valid_next[i] = valid_reg[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_ready = load[0];
    assign m_valid = valid_reg[NS-1];

    // per-axis datapaths
    logic signed [dbva_pkg::COORD_W-1:0] coord [3];
    logic [dbva_pkg::VOL_W-1:0]          axis_vol   [3];
    logic [2:0]                          axis_fault;

    assign coord[0] = s_listener_x;
    assign coord[1] = s_listener_y;
    assign coord[2] = s_listener_z;

    for (genvar a = 0; a < 3; a++) begin : g_axis
        dbva_axis #(
            .GRID_SIZE (GRID_SIZE),
            .BANDS     (BANDS)
        ) u_axis (
            .aclk    (aclk),
            .en      (load[AS-1:0]),
            .coord   (coord[a]),
            .ranges  (ranges_reg[a]),
            .volumes (volumes_reg),
            .src     (src_reg[a]),
            .vol     (axis_vol[a]),
            .fault   (axis_fault[a])
        );
    end

    dbva_mix u_mix (
        .aclk      (aclk),
        .en        (load[NS-1:AS]),
        .vol_x     (axis_vol[0]),
        .vol_y     (axis_vol[1]),
        .vol_z     (axis_vol[2]),
        .fault_in  (|axis_fault),
        .level     (m_level),
        .fault_out (m_table_fault)
    );

`ifndef SYNTHESIS
    // the input side only stalls behind a full pipeline held by the output
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready && (&valid_reg)))
        else $error("input stalled without output back-pressure");

    // no transaction in flight is lost unless one leaves at the output
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(m_valid && m_ready) |=> $countones(valid_reg) >= $past($countones(valid_reg)))
        else $error("transaction dropped inside pipeline");

    // an accepted position occupies the first stage on the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> valid_reg[0])
        else $error("accepted transaction not captured");
`endif

endmodule

/* tb/tb_distance_band_volume_attenuator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_distance_band_volume_attenuator
// Checks level and table fault of the attenuator for directed and random
// listener positions under several band tables and source cells, with random
// gaps on both sides and one long output stall.
// ----------------------------------------------------------------------------
module tb_distance_band_volume_attenuator;

    localparam int G          = dbva_pkg::GRID_SIZE_DEF;
    localparam int NB         = dbva_pkg::BANDS_DEF;
    localparam int VOL_W      = dbva_pkg::VOL_W;
    localparam int RNG_W      = dbva_pkg::RNG_W;
    localparam int CFG_BANDS  = dbva_pkg::CFG_BANDS;
    localparam int COORD_W    = dbva_pkg::COORD_W;
    localparam int FRAC_W     = dbva_pkg::FRAC_W;
    localparam int SRC_W      = dbva_pkg::SRC_W;
    localparam int VOLS_W     = dbva_pkg::VOLS_W;
    localparam int RNGS_W     = dbva_pkg::RNGS_W;
    localparam int CFG_IDX_W  = dbva_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = dbva_pkg::CFG_DATA_W;

    typedef struct packed {
        logic [VOL_W-1:0] level;
        logic             fault;
    } vol_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [COORD_W-1:0] s_listener_x = '0;
    logic signed [COORD_W-1:0] s_listener_y = '0;
    logic signed [COORD_W-1:0] s_listener_z = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [VOL_W-1:0] m_level;
    logic m_table_fault;

    // shadow copy of the configuration
    logic [VOLS_W-1:0] sh_volumes;
    logic [RNGS_W-1:0] sh_ranges [3];
    logic signed [SRC_W-1:0] sh_src [3];

    vol_result_t expected_q[$];
    int mismatches = 0;
    int n_results = 0;
    int n_faults = 0;
    int rx_idle = 0;
    bit hold_off = 1'b0;

    distance_band_volume_attenuator u_dut (.*);

    always #10 aclk = ~aclk;

    function automatic longint band_vol(int k);
        return (k < CFG_BANDS) ? longint'(sh_volumes[VOL_W*k +: VOL_W]) : 0;
    endfunction

    function automatic longint band_rng(int a, int k);
        return (k < CFG_BANDS) ? longint'(sh_ranges[a][RNG_W*k +: RNG_W]) : 0;
    endfunction

    function automatic longint axis_gain(int a, logic signed [COORD_W-1:0] c,
                                         inout bit fault);
        longint whole, ctr, d, sp, ep, sv, ev, den;
        int pick;
        whole = longint'(c >>> FRAC_W);
        ctr = longint'(sh_src[a]) * G + G / 2;
        if ((G % 2) != 0 && ctr < 0) ctr += 1;
        d = whole - ctr;
        if (d < 0) d = -d;
        pick = -1;
        for (int k = 0; k < NB; k++)
            if (pick < 0 && band_rng(a, k) * G <= d) pick = k;
        if (pick < 0) begin
            fault = 1'b1;
            return band_vol(0);
        end
        if (pick == 0) return band_vol(0);
        sv = band_vol(pick);
        ev = band_vol(pick - 1);
        sp = band_rng(a, pick) * G;
        ep = band_rng(a, pick - 1) * G;
        den = ep - sp;
        if (den == 0) begin
            fault = 1'b1;
            return sv;
        end
        return (ev - sv) * (d - sp) / den + sv;
    endfunction

    function automatic vol_result_t predict_volume(logic signed [COORD_W-1:0] x,
            logic signed [COORD_W-1:0] y, logic signed [COORD_W-1:0] z);
        vol_result_t r;
        bit f;
        longint p;
        f = 1'b0;
        p = axis_gain(0, x, f);
        p = p * axis_gain(1, y, f);
        p = p * axis_gain(2, z, f);
        r.level = VOL_W'(p / dbva_pkg::FULL_SCALE_SQ);
        r.fault = f;
        return r;
    endfunction

    task automatic write_reg(dbva_pkg::cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            dbva_pkg::CFG_VOLUMES:  sh_volumes = val[VOLS_W-1:0];
            dbva_pkg::CFG_RANGES_X: sh_ranges[0] = val[RNGS_W-1:0];
            dbva_pkg::CFG_RANGES_Y: sh_ranges[1] = val[RNGS_W-1:0];
            dbva_pkg::CFG_RANGES_Z: sh_ranges[2] = val[RNGS_W-1:0];
            dbva_pkg::CFG_SRC_X:    sh_src[0] = val[SRC_W-1:0];
            dbva_pkg::CFG_SRC_Y:    sh_src[1] = val[SRC_W-1:0];
            dbva_pkg::CFG_SRC_Z:    sh_src[2] = val[SRC_W-1:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // valid stays up after a transaction; drop it only when a gap is drawn
    task automatic send_position(logic signed [COORD_W-1:0] x,
            logic signed [COORD_W-1:0] y, logic signed [COORD_W-1:0] z);
        int gap;
        gap = $urandom_range(3);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_listener_x <= x;
        s_listener_y <= y;
        s_listener_z <= z;
        do @(posedge aclk); while (!s_ready);
        expected_q.push_back(predict_volume(x, y, z));
    endtask

    task automatic drain_pipeline();
        int guard;
        guard = 0;
        s_valid <= 1'b0;
        while (expected_q.size() != 0 && guard < 100000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (dbva_pkg::NUM_STAGES + 4) @(posedge aclk);
    endtask

    // receiver: drops ready for a randomly drawn gap after each transaction, plus a long stall
    always @(posedge aclk) begin
        if (m_valid && m_ready) rx_idle = $urandom_range(3);
        if (hold_off) begin
            m_ready <= 1'b0;
        end else if (rx_idle > 0) begin
            m_ready <= 1'b0;
            rx_idle--;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            vol_result_t want;
            n_results++;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("ERROR: unexpected result level=%0d", m_level);
            end else begin
                want = expected_q.pop_front();
                if (want.fault) n_faults++;
                if (want.level !== m_level || want.fault !== m_table_fault) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: level exp %0d got %0d, fault exp %0b got %0b",
                                 want.level, m_level, want.fault, m_table_fault);
                end
            end
        end
    end

    function automatic logic signed [COORD_W-1:0] near_coord(int a);
        longint ctr, off;
        ctr = longint'(sh_src[a]) * G + G / 2;
        off = longint'($urandom_range(5000)) - 2500;
        return COORD_W'(((ctr + off) <<< FRAC_W) + longint'($urandom_range(4095)));
    endfunction

    // descending ranges (clipped at zero, one equal neighbouring pair when equal_steps is set) and random volumes
    task automatic load_table(bit equal_steps);
        logic [RNGS_W-1:0] r;
        int v;
        for (int a = 0; a < 3; a++) begin
            v = 120 + $urandom_range(135);
            for (int k = 0; k < CFG_BANDS; k++) begin
                r[RNG_W*k +: RNG_W] = RNG_W'(v);
                if (!equal_steps || k != 2) v = v - 1 - $urandom_range(40);
                if (v < 0) v = 0;
            end
            write_reg(dbva_pkg::cfg_reg_t'(dbva_pkg::CFG_RANGES_X + a), r);
            write_reg(dbva_pkg::cfg_reg_t'(dbva_pkg::CFG_SRC_X + a),
                      CFG_DATA_W'($urandom()));
        end
        write_reg(dbva_pkg::CFG_VOLUMES, CFG_DATA_W'({$urandom(), $urandom()}));
    endtask

    task automatic test_extremes();
        write_reg(dbva_pkg::CFG_VOLUMES, CFG_DATA_W'({CFG_BANDS{7'h7F}}));
        for (int a = 0; a < 3; a++) begin
            write_reg(dbva_pkg::cfg_reg_t'(dbva_pkg::CFG_RANGES_X + a),
                      48'h0A_14_1E_28_32_3C);
            write_reg(dbva_pkg::cfg_reg_t'(dbva_pkg::CFG_SRC_X + a), 48'h0000_0000_7FFF);
        end
        send_position(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0);
        send_position(32'sh8000_0000, 32'sh7FFF_FFFF, 32'shFFFF_FFFF);
        drain_pipeline();
        write_reg(dbva_pkg::CFG_SRC_X, 48'h8000);
        write_reg(dbva_pkg::CFG_SRC_Y, 48'hFFFF);
        send_position(32'sh8000_0000, 32'sh0, 32'sh7FFF_FFFF);
        send_position(32'shFFFF_F000, 32'sh0000_0FFF, 32'sh5555_5555);
        drain_pipeline();
    endtask

    task automatic test_special_cases();
        // ascending ranges: no band may match close to the source
        write_reg(dbva_pkg::CFG_VOLUMES, 48'h0155_5555_5555);
        write_reg(dbva_pkg::CFG_RANGES_X, 48'hFF_80_40_20_10_08);
        write_reg(dbva_pkg::CFG_RANGES_Y, 48'h00_00_00_00_00_00);
        write_reg(dbva_pkg::CFG_RANGES_Z, 48'h10_10_10_20_20_20);
        for (int a = 0; a < 3; a++)
            write_reg(dbva_pkg::cfg_reg_t'(dbva_pkg::CFG_SRC_X + a), 48'h0);
        for (int i = 0; i < 12; i++)
            send_position(COORD_W'((i * 9) <<< FRAC_W), COORD_W'(-i <<< 14),
                          COORD_W'((i * 40) <<< FRAC_W));
        drain_pipeline();
        // equal neighboring ranges
        load_table(1'b1);
        for (int i = 0; i < 6; i++) send_position(near_coord(0), near_coord(1), near_coord(2));
        drain_pipeline();
    endtask

    task automatic test_random_tables(int n_items);
        for (int ph = 0; ph < 12; ph++) begin
            load_table($urandom_range(4) == 0);
            if (ph == 3) begin
                fork
                    begin
                        hold_off <= 1'b1;
                        repeat (200) @(posedge aclk);
                        hold_off <= 1'b0;
                    end
                join_none
            end
            for (int i = 0; i < n_items / 12; i++) begin
                if ($urandom_range(9) == 0)
                    send_position($urandom(), $urandom(), $urandom());
                else
                    send_position(near_coord(0), near_coord(1), near_coord(2));
            end
            drain_pipeline();
        end
    endtask

    initial begin
        sh_volumes = '0;
        for (int a = 0; a < 3; a++) begin
            sh_ranges[a] = '0;
            sh_src[a] = '0;
        end
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        send_position(32'sh0, 32'sh0, 32'sh0);
        drain_pipeline();
        test_extremes();
        test_special_cases();
        test_random_tables(1740);
        $display("Covered %0d results (%0d with table fault): reset table, extreme",
                 n_results, n_faults);
        $display("coordinates, unmatched bands and twelve random band tables.");
        if (mismatches == 0 && expected_q.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("%0d errors, %0d results outstanding", mismatches, expected_q.size());
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("Timeout");
        $display("Mismatches found");
        $finish;
    end
endmodule
